// ----- src/pngf_pkg.sv -----
package pngf_pkg;

  localparam int SCORE_W = 23;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 23'h7FFFFF;

  // item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // filter type codes
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;
  localparam int unsigned NUM_FILT  = 5;

  // configuration register indexes
  localparam logic [1:0] REG_EFFORT    = 2'd0;
  localparam logic [1:0] REG_BPP       = 2'd1;
  localparam logic [1:0] REG_ROW_BYTES = 2'd2;

  localparam logic [3:0]  EFFORT_RESET    = 4'd6;
  localparam logic [1:0]  BPP_RESET       = 2'd3;
  localparam logic [15:0] ROW_BYTES_RESET = 16'h8000;
  localparam logic [3:0]  EFFORT_FULL     = 4'd7;

  typedef struct packed {
    logic       clear;
    logic       add;
    logic       pick;
    logic [2:0] idx;
  } score_ctl_t;

  // Filters allowed at a given effort level, one bit per filter type.
  function automatic logic [NUM_FILT-1:0] allowed_mask(input logic [3:0] lv);
    logic [NUM_FILT-1:0] m;
    if (lv == 4'd0) begin
      m = 5'h01;
    end else if (lv inside {[4'd1:4'd3]}) begin
      m = 5'h05;
    end else if (lv inside {[4'd4:4'd6]}) begin
      m = 5'h17;
    end else begin
      m = 5'h1F;
    end
    return m;
  endfunction

  // Magnitude of a filtered byte read as two's complement.
  function automatic logic [7:0] byte_mag(input logic [7:0] v);
    return v[7] ? (~v + 8'd1) : v;
  endfunction

  // True when v is a multiple of three: fold base-4 digits, since 4 = 1 mod 3.
  function automatic logic mod3_zero(input logic [15:0] v);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = '0;
    for (int n = 0; n < 8; n++) begin
      s1 = s1 + 5'(v[2*n +: 2]);
    end
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    return (s3 == 3'd0) || (s3 == 3'd3);
  endfunction

endpackage

// ----- src/pngf_ram.sv -----
module pngf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/pngf_filter_alu.sv -----
module pngf_filter_alu (
  input  logic [2:0] sel_i,
  input  logic [7:0] x_i,
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  input  logic [7:0] c_i,
  output logic [7:0] filt_o,
  output logic [7:0] mag_o
);

  function automatic logic [9:0] abs10(input logic signed [9:0] v);
    return v[9] ? 10'(-v) : 10'(v);
  endfunction

  logic signed [9:0] p;
  logic [9:0] pa, pb, pc;
  logic [7:0] paeth;
  logic [8:0] ab_sum;
  logic [7:0] pred;

  always_comb begin
    p  = $signed({2'b00, a_i}) + $signed({2'b00, b_i}) - $signed({2'b00, c_i});
    pa = abs10(p - $signed({2'b00, a_i}));
    pb = abs10(p - $signed({2'b00, b_i}));
    pc = abs10(p - $signed({2'b00, c_i}));
    if (pa <= pb && pa <= pc) begin
      paeth = a_i;
    end else if (pb <= pc) begin
      paeth = b_i;
    end else begin
      paeth = c_i;
    end
    ab_sum = {1'b0, a_i} + {1'b0, b_i};
    case (sel_i)
      pngf_pkg::FILT_NONE: pred = 8'd0;
      pngf_pkg::FILT_SUB:  pred = a_i;
      pngf_pkg::FILT_UP:   pred = b_i;
      pngf_pkg::FILT_AVG:  pred = ab_sum[8:1];
      default:             pred = paeth;
    endcase
    filt_o = x_i - pred;
    mag_o  = pngf_pkg::byte_mag(filt_o);
  end

endmodule

// ----- src/pngf_score_bank.sv -----
module pngf_score_bank (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pngf_pkg::score_ctl_t                ctl_i,
  input  logic [7:0]                          mag_i,
  input  logic [pngf_pkg::NUM_FILT-1:0]       mask_i,
  output logic [2:0]                          chosen_o
);

  logic [pngf_pkg::SCORE_W-1:0] score_q [pngf_pkg::NUM_FILT];
  logic [pngf_pkg::SCORE_W-1:0] best_score_q;
  logic [2:0]                   best_q;
  logic [pngf_pkg::SCORE_W-1:0] cur;
  logic [pngf_pkg::SCORE_W:0]   sum;
  logic [pngf_pkg::SCORE_W-1:0] sat;

  always_comb begin
    cur = score_q[ctl_i.idx];
    sum = {1'b0, cur} + (pngf_pkg::SCORE_W + 1)'(mag_i);
    sat = sum[pngf_pkg::SCORE_W] ? pngf_pkg::SCORE_MAX : sum[pngf_pkg::SCORE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < pngf_pkg::NUM_FILT; n++) begin
        score_q[n] <= '0;
      end
      best_q       <= pngf_pkg::FILT_NONE;
      best_score_q <= '0;
    end else begin
      if (ctl_i.clear) begin
        for (int n = 0; n < pngf_pkg::NUM_FILT; n++) begin
          score_q[n] <= '0;
        end
      end else if (ctl_i.add) begin
        score_q[ctl_i.idx] <= sat;
      end
      // None is always allowed, so the first step seeds the running minimum
      if (ctl_i.pick) begin
        if (ctl_i.idx == pngf_pkg::FILT_NONE) begin
          best_q       <= pngf_pkg::FILT_NONE;
          best_score_q <= cur;
        end else if (mask_i[ctl_i.idx] && cur < best_score_q) begin
          best_q       <= ctl_i.idx;
          best_score_q <= cur;
        end
      end
    end
  end

  assign chosen_o = best_q;

endmodule

// ----- src/png_row_filter_selector.sv -----
// PNG row filter selector.
// Input channel (in_valid_i/in_ready_o) carries op_i, pixel_byte_i and frame_start_i.
// A load (op 0) stores one raw row byte; a drain (op 1) returns one result byte on
// the output channel (out_valid_o/out_ready_i): first the chosen filter type, then
// the filtered bytes of the row, last_o marking the final one. Loads while the row
// is being drained, and drains while it is being loaded, are dropped without result.
// Configuration goes through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user writes it only
// while the block is idle, which the block itself does not enforce. One item at a time:
// in_ready_o is high only when the sequencer is idle. After a transfer, a dropped item
// or an unsampled load leaves the sequencer idle, but a load that ends the row runs the
// minimum search, one score per cycle; a sampled load first runs three row-store reads
// on the single read port, a capture, then five score updates through the shared filter
// unit. A drain of the type byte goes to the output step; a filtered byte takes four
// reads, capture, output. The result lands in an output register; if the receiver
// stalls, the sequencer holds in its output step until that register frees up.
// Reset clears all control state and the scores, and sets effort 6, 3 bytes per
// pixel and 32768-byte rows. The row store is not cleared.
module png_row_filter_selector #(
  parameter int MAX_ROW_BYTES = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  pixel_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        is_filter_type_o,
  output logic        last_o
);

  localparam int IDX_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int CNT_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int ADDR_W = IDX_W + 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_RDA   = 10'b00_0000_0010,
    S_RDB   = 10'b00_0000_0100,
    S_RDC   = 10'b00_0000_1000,
    S_RDX   = 10'b00_0001_0000,
    S_CAPC  = 10'b00_0010_0000,
    S_CAPX  = 10'b00_0100_0000,
    S_SCORE = 10'b00_1000_0000,
    S_PICK  = 10'b01_0000_0000,
    S_EMIT  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [3:0]       effort_q;
  logic [1:0]       bpp_q;
  logic [15:0]      row_bytes_q;
  logic [CNT_W-1:0] byte_idx_q;
  logic             draining_q, bank_q, prev_valid_q;

  logic [ADDR_W-1:0] addr_a_q, addr_b_q, addr_c_q, addr_x_q;
  logic              a_zero_q, b_zero_q, row_end_q, is_drain_q, emit_type_q, last_q;
  logic [7:0]        x_q, a_q, b_q, c_q;
  logic [2:0]        k_q;

  logic [7:0] out_byte_q;
  logic       out_valid_q, out_type_q, out_last_q;

  // derived configuration
  logic [1:0]       bpp_eff;
  logic             full_effort;
  logic [16:0]      len_wide;
  logic [CNT_W-1:0] len;
  logic [pngf_pkg::NUM_FILT-1:0] mask;

  always_comb begin
    bpp_eff     = (bpp_q == 2'd0) ? 2'd1 : bpp_q;
    full_effort = effort_q >= pngf_pkg::EFFORT_FULL;
    if (row_bytes_q == 16'd0) begin
      len_wide = 17'd1;
    end else if ({1'b0, row_bytes_q} > 17'(MAX_ROW_BYTES)) begin
      len_wide = 17'(MAX_ROW_BYTES);
    end else begin
      len_wide = {1'b0, row_bytes_q};
    end
    len  = len_wide[CNT_W-1:0];
    mask = pngf_pkg::allowed_mask(effort_q);
  end

  // item decode
  logic             acc, load_go, drain_go;
  logic [IDX_W-1:0] i_load, i_drain, i_item, i_left;
  logic [CNT_W-1:0] i_next, drain_dec;
  logic [15:0]      i16;
  logic [1:0]       low_zero_bits;
  logic             low_ok, sampled, row_end, below_bpp, prev_eff, drain_last;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    acc      = in_valid_i && in_ready_o;
    load_go  = acc && (op_i == pngf_pkg::OP_LOAD) && !draining_q;
    drain_go = acc && (op_i == pngf_pkg::OP_DRAIN) && draining_q;

    i_load    = frame_start_i ? '0 : byte_idx_q[IDX_W-1:0];
    drain_dec = byte_idx_q - CNT_W'(1);
    i_drain   = drain_dec[IDX_W-1:0];
    i_item    = (op_i == pngf_pkg::OP_LOAD) ? i_load : i_drain;
    i_left    = i_item - IDX_W'(bpp_eff);
    below_bpp = 17'(i_item) < 17'(bpp_eff);
    prev_eff  = prev_valid_q && !((op_i == pngf_pkg::OP_LOAD) && frame_start_i);

    i_next  = CNT_W'(i_load) + CNT_W'(1);
    row_end = i_next >= len;
    drain_last = byte_idx_q >= len;

    // stride is bpp * 4 below full effort, bpp at full effort
    i16 = 16'(i_load);
    low_zero_bits = ((bpp_eff == 2'd2) ? 2'd1 : 2'd0) + (full_effort ? 2'd0 : 2'd2);
    case (low_zero_bits)
      2'd0:    low_ok = 1'b1;
      2'd1:    low_ok = !i16[0];
      2'd2:    low_ok = (i16[1:0] == 2'd0);
      default: low_ok = (i16[2:0] == 3'd0);
    endcase
    sampled = low_ok && ((bpp_eff != 2'd3) || pngf_pkg::mod3_zero(i16));
  end

  // row store: the current row in bank bank_q, the previous row in the other
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  always_comb begin
    ram_re = 1'b1;
    case (state_q)
      S_RDA:   ram_raddr = addr_a_q;
      S_RDB:   ram_raddr = addr_b_q;
      S_RDC:   ram_raddr = addr_c_q;
      S_RDX:   ram_raddr = addr_x_q;
      default: begin
        ram_raddr = addr_a_q;
        ram_re    = 1'b0;
      end
    endcase
  end

  pngf_ram #(
    .WIDTH (8),
    .DEPTH (2 ** ADDR_W)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (load_go),
    .waddr_i ({bank_q, i_load}),
    .wdata_i (pixel_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared filter unit and score bank
  logic [2:0]           alu_sel, chosen;
  logic [7:0]           filt, mag;
  pngf_pkg::score_ctl_t score_ctl;

  assign alu_sel = (state_q == S_SCORE) ? k_q : chosen;

  pngf_filter_alu u_alu (
    .sel_i  (alu_sel),
    .x_i    (x_q),
    .a_i    (a_q),
    .b_i    (b_q),
    .c_i    (c_q),
    .filt_o (filt),
    .mag_o  (mag)
  );

  always_comb begin
    score_ctl.clear = load_go && (i_load == '0);
    score_ctl.add   = (state_q == S_SCORE);
    score_ctl.pick  = (state_q == S_PICK);
    score_ctl.idx   = k_q;
  end

  pngf_score_bank u_scores (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (score_ctl),
    .mag_i    (mag),
    .mask_i   (mask),
    .chosen_o (chosen)
  );

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (load_go) begin
          if (sampled) begin
            state_d = S_RDA;
          end else if (row_end) begin
            state_d = S_PICK;
          end
        end else if (drain_go) begin
          state_d = (byte_idx_q == '0) ? S_EMIT : S_RDA;
        end
      end
      S_RDA:   state_d = S_RDB;
      S_RDB:   state_d = S_RDC;
      S_RDC:   state_d = is_drain_q ? S_RDX : S_CAPC;
      S_RDX:   state_d = S_CAPX;
      S_CAPX:  state_d = S_EMIT;
      S_CAPC:  state_d = S_SCORE;
      S_SCORE: begin
        if (k_q == pngf_pkg::FILT_PAETH) begin
          state_d = row_end_q ? S_PICK : S_IDLE;
        end
      end
      S_PICK: begin
        if (k_q == pngf_pkg::FILT_PAETH) begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      effort_q     <= pngf_pkg::EFFORT_RESET;
      bpp_q        <= pngf_pkg::BPP_RESET;
      row_bytes_q  <= pngf_pkg::ROW_BYTES_RESET;
      byte_idx_q   <= '0;
      draining_q   <= 1'b0;
      bank_q       <= 1'b0;
      prev_valid_q <= 1'b0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          pngf_pkg::REG_EFFORT:    effort_q    <= cfg_wdata_i[3:0];
          pngf_pkg::REG_BPP:       bpp_q       <= cfg_wdata_i[1:0];
          pngf_pkg::REG_ROW_BYTES: row_bytes_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (load_go) begin
        if (frame_start_i) begin
          prev_valid_q <= 1'b0;
        end
        if (row_end) begin
          byte_idx_q <= '0;
          draining_q <= 1'b1;
        end else begin
          byte_idx_q <= i_next;
        end
      end else if (drain_go) begin
        if (byte_idx_q == '0) begin
          byte_idx_q <= CNT_W'(1);
        end else if (drain_last) begin
          // row done: it becomes the previous row
          bank_q       <= !bank_q;
          prev_valid_q <= 1'b1;
          draining_q   <= 1'b0;
          byte_idx_q   <= '0;
        end else begin
          byte_idx_q <= byte_idx_q + CNT_W'(1);
        end
      end

      if ((state_q == S_SCORE) || (state_q == S_PICK)) begin
        k_q <= (k_q == pngf_pkg::FILT_PAETH) ? '0 : k_q + 3'd1;
      end

      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      addr_a_q    <= {bank_q, i_left};
      addr_b_q    <= {!bank_q, i_item};
      addr_c_q    <= {!bank_q, i_left};
      addr_x_q    <= {bank_q, i_item};
      a_zero_q    <= below_bpp;
      b_zero_q    <= !prev_eff;
      row_end_q   <= row_end;
      is_drain_q  <= (op_i == pngf_pkg::OP_DRAIN);
      emit_type_q <= (byte_idx_q == '0);
      last_q      <= (byte_idx_q != '0) && drain_last;
      x_q         <= pixel_byte_i;
    end
    if (state_q == S_RDB) begin
      a_q <= a_zero_q ? 8'd0 : ram_rdata;
    end
    if (state_q == S_RDC) begin
      b_q <= b_zero_q ? 8'd0 : ram_rdata;
    end
    if (state_q == S_RDX || state_q == S_CAPC) begin
      c_q <= (a_zero_q || b_zero_q) ? 8'd0 : ram_rdata;
    end
    if (state_q == S_CAPX) begin
      x_q <= ram_rdata;
    end
    if (state_q == S_EMIT && out_free) begin
      out_byte_q <= emit_type_q ? {5'd0, chosen} : filt;
      out_type_q <= emit_type_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign is_filter_type_o = out_type_q;
  assign last_o           = out_last_q;

endmodule

// ----- src/pngf_checker.sv -----
module pngf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       is_filter_type_o,
  input logic       last_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(is_filter_type_o) && $stable(last_o))
    else $error("stalled result changed");

  // the type byte names a filter and never closes a row
  a_type_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_filter_type_o |-> (out_byte_o <= 8'd4) && !last_o)
    else $error("bad filter type byte");

  // a fresh result comes out of a busy sequencer
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while idle");

endmodule

bind png_row_filter_selector pngf_checker u_pngf_checker (.*);

// ----- sim/png_row_filter_checker.sv -----
`timescale 1ns / 100ps

module png_row_filter_checker
  import pngf_pkg::*;
#(
  parameter int MAX_ROW_BYTES = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        op_i,
  input  logic [7:0]  pixel_byte_i,
  input  logic        frame_start_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        is_filter_type_i,
  input  logic        last_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       type_byte;
    logic       last;
  } out_beat_t;

  out_beat_t out_bytes_q[$];

  // two row banks: current row and the row above it
  bit   [7:0]         row_mem [2*MAX_ROW_BYTES];
  logic [3:0]         effort_q;
  logic [1:0]         bpp_q;
  logic [15:0]        row_bytes_q;
  logic               bank_q;
  logic               above_ok_q;
  logic               draining_q;
  logic [SCORE_W-1:0] score_q [NUM_FILT];
  int unsigned        pos_q;
  logic [2:0]         pick_q;
  int unsigned        fail_n;

  function automatic int unsigned row_length();
    int unsigned r;
    r = row_bytes_q;
    if (r == 0) r = 1;
    if (r > MAX_ROW_BYTES) r = MAX_ROW_BYTES;
    return r;
  endfunction

  function automatic int unsigned pixel_span();
    return (bpp_q == 2'd0) ? 1 : int'(bpp_q);
  endfunction

  function automatic logic [3:0] level();
    return (effort_q > 4'd9) ? 4'd9 : effort_q;
  endfunction

  function automatic logic [NUM_FILT-1:0] filters_at(input logic [3:0] lv);
    logic [NUM_FILT-1:0] m;
    m = '0;
    m[FILT_NONE] = 1'b1;
    if (lv >= 4'd1) m[FILT_UP] = 1'b1;
    if (lv >= 4'd4) begin
      m[FILT_SUB]   = 1'b1;
      m[FILT_PAETH] = 1'b1;
    end
    if (lv >= EFFORT_FULL) m[FILT_AVG] = 1'b1;
    return m;
  endfunction

  function automatic logic [7:0] mem_rd(input logic bank, input int unsigned i);
    return row_mem[bank ? MAX_ROW_BYTES + i : i];
  endfunction

  function automatic void near_bytes(input int unsigned i, output logic [7:0] a,
                                     output logic [7:0] b, output logic [7:0] c);
    int unsigned span;
    span = pixel_span();
    a = 8'd0;
    b = 8'd0;
    c = 8'd0;
    if (i >= span) a = mem_rd(bank_q, i - span);
    if (above_ok_q) begin
      b = mem_rd(!bank_q, i);
      if (i >= span) c = mem_rd(!bank_q, i - span);
    end
  endfunction

  function automatic logic [7:0] paeth_guess(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
    int p, da, db, dc;
    p  = int'(a) + int'(b) - int'(c);
    da = p - int'(a);
    db = p - int'(b);
    dc = p - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  function automatic logic [7:0] filtered(input logic [2:0] k, input logic [7:0] x,
                                          input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
    logic [8:0] avg;
    logic [7:0] pred;
    avg = ({1'b0, a} + {1'b0, b}) >> 1;
    case (k)
      FILT_NONE: pred = 8'd0;
      FILT_SUB:  pred = a;
      FILT_UP:   pred = b;
      FILT_AVG:  pred = avg[7:0];
      default:   pred = paeth_guess(a, b, c);
    endcase
    return x - pred;
  endfunction

  // add the magnitude of a filtered byte read as signed, saturating
  function automatic logic [SCORE_W-1:0] score_add(input logic [SCORE_W-1:0] s,
                                                   input logic [7:0] v);
    logic [SCORE_W:0] sum;
    logic [7:0]       mag;
    mag = v[7] ? 8'(9'd256 - {1'b0, v}) : v;
    sum = s + mag;
    return (sum > SCORE_MAX) ? SCORE_MAX : sum[SCORE_W-1:0];
  endfunction

  // lowest score among allowed filters; ties keep the lower filter number
  function automatic logic [2:0] best_filter();
    logic [NUM_FILT-1:0] m;
    logic [2:0]          best;
    logic [SCORE_W-1:0]  bs;
    logic                seen;
    m    = filters_at(level());
    best = FILT_NONE;
    bs   = '0;
    seen = 1'b0;
    for (int k = 0; k < NUM_FILT; k++) begin
      if (m[k] && (!seen || score_q[k] < bs)) begin
        bs   = score_q[k];
        best = 3'(k);
        seen = 1'b1;
      end
    end
    return best;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic [7:0]  a, b, c, v;
    int unsigned i, len, stride;
    out_beat_t   got, want;
    if (!rst_ni) begin
      effort_q    = EFFORT_RESET;
      bpp_q       = BPP_RESET;
      row_bytes_q = ROW_BYTES_RESET;
      bank_q      = 1'b0;
      above_ok_q  = 1'b0;
      draining_q  = 1'b0;
      pos_q       = 0;
      pick_q      = FILT_NONE;
      for (int k = 0; k < NUM_FILT; k++) score_q[k] = '0;
      out_bytes_q.delete();
      fail_n       = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_EFFORT:    effort_q    = cfg_wdata_i[3:0];
          REG_BPP:       bpp_q       = cfg_wdata_i[1:0];
          REG_ROW_BYTES: row_bytes_q = cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        len = row_length();
        if (op_i == OP_LOAD) begin
          if (!draining_q) begin
            if (frame_start_i) begin
              above_ok_q = 1'b0;
              pos_q      = 0;
            end
            i = pos_q;
            if (i >= MAX_ROW_BYTES) i = MAX_ROW_BYTES - 1;
            if (i == 0) begin
              for (int k = 0; k < NUM_FILT; k++) score_q[k] = '0;
            end
            row_mem[bank_q ? MAX_ROW_BYTES + i : i] = pixel_byte_i;
            stride = pixel_span() * ((level() >= EFFORT_FULL) ? 1 : 4);
            if (i % stride == 0) begin
              near_bytes(i, a, b, c);
              for (int k = 0; k < NUM_FILT; k++) begin
                score_q[k] = score_add(score_q[k], filtered(3'(k), pixel_byte_i, a, b, c));
              end
            end
            if (i + 1 >= len) begin
              pick_q     = best_filter();
              draining_q = 1'b1;
              pos_q      = 0;
            end else begin
              pos_q = i + 1;
            end
          end
        end else if (draining_q) begin
          if (pos_q == 0) begin
            out_bytes_q.push_back('{data: 8'(pick_q), type_byte: 1'b1, last: 1'b0});
            pos_q = 1;
          end else begin
            i = pos_q - 1;
            near_bytes(i, a, b, c);
            v = filtered(pick_q, mem_rd(bank_q, i), a, b, c);
            out_bytes_q.push_back('{data: v, type_byte: 1'b0, last: pos_q >= len});
            if (pos_q >= len) begin
              // row done: it becomes the row above
              bank_q     = !bank_q;
              above_ok_q = 1'b1;
              draining_q = 1'b0;
              pos_q      = 0;
            end else begin
              pos_q++;
            end
          end
        end
      end

      if (out_valid_i && out_ready_i) begin
        got = '{data: out_byte_i, type_byte: is_filter_type_i, last: last_i};
        if (out_bytes_q.size() == 0) begin
          if (fail_n < 10) begin
            $display("%0t: unexpected result: byte %02h type %0b last %0b",
                     $time, got.data, got.type_byte, got.last);
          end
          fail_n++;
        end else begin
          want = out_bytes_q.pop_front();
          if (got !== want) begin
            if (fail_n < 10) begin
              $display("%0t: result mismatch: expected byte %02h type %0b last %0b, got byte %02h type %0b last %0b",
                       $time, want.data, want.type_byte, want.last,
                       got.data, got.type_byte, got.last);
            end
            fail_n++;
          end
        end
      end

      pending_o    <= out_bytes_q.size();
      fail_count_o <= fail_n;
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import pngf_pkg::*;

  localparam int          MAX_ROW       = 32768;
  localparam int unsigned IDLE_PCT      = 15;
  localparam int unsigned NOISE_PCT     = 6;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned QUIET_LIMIT   = 20000;
  localparam int unsigned HOLD_AT       = 1500;
  localparam int unsigned HOLD_LEN      = 400;
  localparam int unsigned RX_CALM_AT    = 5000;
  localparam int unsigned RX_CALM_LEN   = 4000;
  localparam int unsigned TX_CALM_AT    = 600;
  localparam int unsigned TX_CALM_LEN   = 300;

  typedef enum int unsigned {
    TEX_NOISE,
    TEX_PLANE,
    TEX_FLAT_ROWS,
    TEX_REPEAT_ROWS,
    TEX_BLANK
  } texture_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        op_i;
  logic [7:0]  pixel_byte_i;
  logic        frame_start_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        is_filter_type_o;
  logic        last_o;
  int unsigned pending_w;
  int unsigned fail_w;

  // sender's view of where the row stands
  logic        in_drain;
  logic        new_frame;
  int unsigned row_pos;
  int unsigned row_len;
  int unsigned rows_done;
  int unsigned sent_n;

  png_row_filter_selector #(
    .MAX_ROW_BYTES(MAX_ROW)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .pixel_byte_i    (pixel_byte_i),
    .frame_start_i   (frame_start_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .is_filter_type_o(is_filter_type_o),
    .last_o          (last_o)
  );

  png_row_filter_checker #(
    .MAX_ROW_BYTES(MAX_ROW)
  ) filter_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .op_i            (op_i),
    .pixel_byte_i    (pixel_byte_i),
    .frame_start_i   (frame_start_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_i      (out_byte_o),
    .is_filter_type_i(is_filter_type_o),
    .last_i          (last_o),
    .pending_o       (pending_w),
    .fail_count_o    (fail_w)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin : receiver
    int unsigned ticks;
    ticks = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      ticks++;
      // long hold-off lets the block fill up and stall its input
      if (ticks >= HOLD_AT && ticks < HOLD_AT + HOLD_LEN) begin
        out_ready_i <= 1'b0;
      end else if (ticks >= RX_CALM_AT && ticks < RX_CALM_AT + RX_CALM_LEN) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [7:0] texture_byte(input texture_t tex);
    case (tex)
      TEX_PLANE:       return 8'(row_pos * 3 + rows_done * 5);
      TEX_FLAT_ROWS:   return 8'(rows_done * 29 + 7);
      TEX_REPEAT_ROWS: return 8'(row_pos * 37 + 11);
      TEX_BLANK:       return 8'h00;
      default:         return 8'($urandom);
    endcase
  endfunction

  task automatic push_item(input logic op, input logic [7:0] data, input logic fs);
    while (!(sent_n >= TX_CALM_AT && sent_n < TX_CALM_AT + TX_CALM_LEN) &&
           $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    pixel_byte_i  <= data;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_n++;
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic wait_quiet();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_w != 0 && guard < QUIET_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [3:0] lvl, input logic [1:0] bpp,
                               input logic [15:0] rows);
    int unsigned len_next;
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_EFFORT;
    cfg_wdata_i <= 16'(lvl);
    @(posedge clk_i);
    cfg_idx_i   <= REG_BPP;
    cfg_wdata_i <= 16'(bpp);
    @(posedge clk_i);
    cfg_idx_i   <= REG_ROW_BYTES;
    cfg_wdata_i <= rows;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    len_next = (rows == 0) ? 1 : ((rows > MAX_ROW) ? MAX_ROW : rows);
    // a longer row must not look at unwritten bytes of the row above
    new_frame = (len_next > row_len) || ($urandom_range(1) == 1);
    row_len   = len_next;
  endtask

  // well-formed rows with content of the given texture, salted with wrong-phase items
  task automatic run_items(input int unsigned count, input texture_t tex);
    int unsigned done_n;
    logic        fs;
    done_n = 0;
    while (done_n < count || in_drain || row_pos != 0) begin
      if ($urandom_range(99) < NOISE_PCT) begin
        push_item(in_drain ? OP_LOAD : OP_DRAIN, 8'($urandom), 1'($urandom));
      end else if (!in_drain) begin
        fs = new_frame || (row_len <= 64 && $urandom_range(99) < 2);
        new_frame = 1'b0;
        if (fs) row_pos = 0;
        push_item(OP_LOAD, texture_byte(tex), fs);
        row_pos++;
        if (row_pos >= row_len) begin
          in_drain = 1'b1;
          row_pos  = 0;
        end
        done_n++;
      end else begin
        push_item(OP_DRAIN, 8'($urandom), $urandom_range(9) == 0);
        row_pos++;
        if (row_pos > row_len) begin
          in_drain = 1'b0;
          row_pos  = 0;
          rows_done++;
        end
        done_n++;
      end
    end
  endtask

  task automatic run_phase(input logic [3:0] lvl, input logic [1:0] bpp,
                           input logic [15:0] rows, input texture_t tex,
                           input int unsigned count);
    apply_setting(lvl, bpp, rows);
    run_items(count, tex);
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_EFFORT;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    op_i          = OP_LOAD;
    pixel_byte_i  = '0;
    frame_start_i = 1'b0;
    in_drain      = 1'b0;
    new_frame     = 1'b1;
    row_pos       = 0;
    row_len       = MAX_ROW;
    rows_done     = 0;
    sent_n        = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corner bytes on a first row, then on a row with a row above
    apply_setting(4'd9, 2'd1, 16'd4);
    push_item(OP_DRAIN, 8'hA5, 1'b1);
    push_item(OP_LOAD, 8'h00, 1'b1);
    push_item(OP_LOAD, 8'hFF, 1'b0);
    push_item(OP_LOAD, 8'h80, 1'b0);
    push_item(OP_LOAD, 8'h7F, 1'b0);
    push_item(OP_LOAD, 8'h55, 1'b1);
    push_item(OP_DRAIN, 8'h00, 1'b0);
    push_item(OP_DRAIN, 8'hFF, 1'b1);
    repeat (3) push_item(OP_DRAIN, 8'h00, 1'b0);
    push_item(OP_LOAD, 8'h01, 1'b0);
    push_item(OP_LOAD, 8'hFE, 1'b0);
    push_item(OP_LOAD, 8'h7F, 1'b0);
    push_item(OP_LOAD, 8'h80, 1'b0);
    repeat (5) push_item(OP_DRAIN, 8'h00, 1'b0);
    rows_done = 2;

    run_phase(4'd0, 2'd1, 16'd0, TEX_NOISE, 110);
    run_phase(4'd9, 2'd3, 16'd1, TEX_PLANE, 110);
    run_phase(4'd15, 2'd0, 16'd7, TEX_FLAT_ROWS, 110);
    run_phase(4'd2, 2'd2, 16'd12, TEX_REPEAT_ROWS, 110);
    run_phase(4'd4, 2'd3, 16'd24, TEX_BLANK, 110);
    run_phase(4'd6, 2'd1, 16'd16, TEX_PLANE, 110);
    run_phase(4'd8, 2'd2, 16'd33, TEX_NOISE, 110);
    for (int n = 0; n < 7; n++) begin
      run_phase(4'($urandom_range(15)), 2'($urandom_range(3)),
                16'($urandom_range(40)), texture_t'($urandom_range(4)), 110);
    end
    // one full-length row, with a row length beyond the store
    run_phase(4'd5, 2'd3, 16'hFFFF, TEX_NOISE, 1);

    wait_quiet();
    if (fail_w == 0 && pending_w == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
